FILE: sv/qdec_pkg.sv
package qdec_pkg;

  // Timestamp width used for the debounce distance
  localparam int TIME_BITS = 32;
  localparam int POS_BITS  = 8;
  localparam int DEB_BITS  = 8;

  // Reset values of the configuration registers
  localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 8'd2;
  localparam logic                INVERT_RESET   = 1'b1;

  // Saturation limits of the position
  localparam logic signed [POS_BITS-1:0] POS_MAX = 8'sd127;
  localparam logic signed [POS_BITS-1:0] POS_MIN = -8'sd128;

  typedef enum logic [2:0] {
    ACT_PIN_CHANGE   = 3'd0,
    ACT_INIT         = 3'd1,
    ACT_RESET_POS    = 3'd2,
    ACT_READ_DELTA   = 3'd3,
    ACT_READ_CHANGED = 3'd4
  } action_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_INVERT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t              action;
    logic [TIME_BITS-1:0] time_ms;
    logic [1:0]           ab;
  } item_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position;
    logic signed [POS_BITS-1:0] delta;
    logic                       changed_flag;
    logic                       accepted;
  } result_t;

  // 4x Gray transition table, indexed by {previous AB, new AB}
  function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/qdec_in_stage.sv
module qdec_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  qdec_pkg::item_t   in_item,
  input  logic              advance,
  output logic              valid,
  output qdec_pkg::item_t   item
);

  logic load;

  // Take a new beat when the register is empty or is moving on this cycle
  assign in_stall = valid && !advance;
  assign load     = in_valid && !in_stall;

  // Hold the valid bit until the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

FILE: sv/qdec_core.sv
module qdec_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  qdec_pkg::cfg_reg_t              cfg_index,
  input  logic [qdec_pkg::DEB_BITS-1:0]   cfg_data,
  input  logic                            fire,
  input  qdec_pkg::item_t                 item,
  output qdec_pkg::result_t               res
);

  logic [qdec_pkg::DEB_BITS-1:0]  debounce;
  logic                           invert;
  logic signed [qdec_pkg::POS_BITS-1:0] count;
  logic signed [qdec_pkg::POS_BITS-1:0] count_at_last_read;
  logic [1:0]                     prev_ab;
  logic [qdec_pkg::TIME_BITS-1:0] last_time;
  logic                           moved;

  logic signed [qdec_pkg::POS_BITS-1:0] count_next;
  logic signed [qdec_pkg::POS_BITS-1:0] count_at_last_read_next;
  logic [1:0]                     prev_ab_next;
  logic [qdec_pkg::TIME_BITS-1:0] last_time_next;
  logic                           moved_next;

  logic [qdec_pkg::TIME_BITS-1:0] elapsed;
  logic                           pass;
  logic signed [1:0]              step_raw;
  logic signed [1:0]              step;
  logic                           step_up;
  logic                           step_down;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= qdec_pkg::DEBOUNCE_RESET;
      invert   <= qdec_pkg::INVERT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qdec_pkg::REG_DEBOUNCE: debounce <= cfg_data;
        qdec_pkg::REG_INVERT:   invert   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Debounce distance with wrap, and the decoded step
  assign elapsed   = item.time_ms - last_time;
  assign pass      = elapsed >= qdec_pkg::TIME_BITS'(debounce);
  assign step_raw  = qdec_pkg::gray_step({prev_ab, item.ab});
  assign step      = invert ? -step_raw : step_raw;
  assign step_up   = (step == 2'sd1);
  assign step_down = (step == -2'sd1);

  // Next state and result for the item in the input register
  always_comb begin
    count_next              = count;
    count_at_last_read_next = count_at_last_read;
    prev_ab_next            = prev_ab;
    last_time_next          = last_time;
    moved_next              = moved;
    res.delta               = '0;
    res.accepted            = 1'b0;
    unique case (item.action)
      qdec_pkg::ACT_PIN_CHANGE: begin
        if (pass) begin
          res.accepted   = 1'b1;
          last_time_next = item.time_ms;
          prev_ab_next   = item.ab;
          if (step_up || step_down) begin
            moved_next = 1'b1;
          end
          if (step_up && count != qdec_pkg::POS_MAX) begin
            count_next = count + 8'sd1;
          end else if (step_down && count != qdec_pkg::POS_MIN) begin
            count_next = count - 8'sd1;
          end
        end
      end
      qdec_pkg::ACT_INIT: begin
        prev_ab_next            = item.ab;
        count_next              = '0;
        count_at_last_read_next = '0;
        moved_next              = 1'b0;
      end
      qdec_pkg::ACT_RESET_POS: begin
        count_next = '0;
        moved_next = 1'b1;
      end
      qdec_pkg::ACT_READ_DELTA: begin
        res.delta               = count - count_at_last_read;
        count_at_last_read_next = count;
      end
      default: ;
    endcase
    res.position     = count_next;
    res.changed_flag = moved_next;
    // Drop the flag after reporting it
    if (item.action == qdec_pkg::ACT_READ_CHANGED) begin
      moved_next = 1'b0;
    end
  end

  // Decoder state, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      count              <= '0;
      count_at_last_read <= '0;
      prev_ab            <= '0;
      last_time          <= '0;
      moved              <= 1'b0;
    end else if (fire) begin
      count              <= count_next;
      count_at_last_read <= count_at_last_read_next;
      prev_ab            <= prev_ab_next;
      last_time          <= last_time_next;
      moved              <= moved_next;
    end
  end

  a_accept_only_pin: assert property (@(posedge clk) disable iff (rst)
    fire && res.accepted |-> item.action == qdec_pkg::ACT_PIN_CHANGE)
    else $error("accepted flag on an action other than pin change");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == qdec_pkg::ACT_INIT |=> count == '0 && !moved)
    else $error("initialize did not clear position and flag");

  a_read_changed_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == qdec_pkg::ACT_READ_CHANGED |=> !moved)
    else $error("changed flag survived a read");

  a_read_delta_syncs: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == qdec_pkg::ACT_READ_DELTA |=> count_at_last_read == count)
    else $error("read position not updated after delta read");

endmodule

FILE: sv/qdec_out_stage.sv
module qdec_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  qdec_pkg::result_t   s_res,
  output logic                ready,
  output logic                fire,
  output logic                out_valid,
  input  logic                out_stall,
  output qdec_pkg::result_t   out_res
);

  // Move a result in when the register is empty or drains this cycle
  assign ready = !out_valid || !out_stall;
  assign fire  = s_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= s_res;
    end
  end

endmodule

FILE: sv/quadrature_decoder_saturating_top.sv
// Path: an accepted beat is held in the input register, and its result is then
// registered in the result register before it shows on the outputs.
// Throughput: one item per cycle while out_stall is low; the update of the small
// state registers is the single combinational step between the two registers.
// Reset (rst, synchronous): both stages empty, position, read mark, AB and timestamp
// zero, changed flag clear, debounce 2 ms, direction inverted.
module quadrature_decoder_saturating_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [qdec_pkg::DEB_BITS-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           action,
  input  logic [qdec_pkg::TIME_BITS-1:0]       time_ms,
  input  logic                                 pin_a,
  input  logic                                 pin_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qdec_pkg::POS_BITS-1:0] position,
  output logic signed [qdec_pkg::POS_BITS-1:0] delta,
  output logic                                 changed_flag,
  output logic                                 accepted
);

  qdec_pkg::item_t   in_item;
  qdec_pkg::item_t   s_item;
  qdec_pkg::result_t s_res;
  qdec_pkg::result_t out_res;
  logic              s_valid;
  logic              ready;
  logic              fire;

  // Pack the input beat
  assign in_item.action  = qdec_pkg::action_t'(action);
  assign in_item.time_ms = time_ms;
  assign in_item.ab      = {pin_a, pin_b};

  qdec_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (ready),
    .valid    (s_valid),
    .item     (s_item)
  );

  qdec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (qdec_pkg::cfg_reg_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s_item),
    .res       (s_res)
  );

  qdec_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_valid),
    .s_res     (s_res),
    .ready     (ready),
    .fire      (fire),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result beat
  assign position     = out_res.position;
  assign delta        = out_res.delta;
  assign changed_flag = out_res.changed_flag;
  assign accepted     = out_res.accepted;

endmodule

FILE: test/quadrature_decoder_saturating_checker.sv
module quadrature_decoder_saturating_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [qdec_pkg::DEB_BITS-1:0]        cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [2:0]                           action,
  input  logic [qdec_pkg::TIME_BITS-1:0]       time_ms,
  input  logic                                 pin_a,
  input  logic                                 pin_b,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [qdec_pkg::POS_BITS-1:0] position,
  input  logic signed [qdec_pkg::POS_BITS-1:0] delta,
  input  logic                                 changed_flag,
  input  logic                                 accepted,
  output int                                   errors,
  output int                                   pending
);

  import qdec_pkg::*;

  // Decoder state as it should be after every accepted beat
  logic signed [POS_BITS-1:0] pos_q;
  logic signed [POS_BITS-1:0] read_mark;
  logic [1:0]                 last_ab;
  logic [TIME_BITS-1:0]       last_hit;
  logic                       moved_q;
  logic [DEB_BITS-1:0]        debounce_q;
  logic                       invert_q;

  result_t expected_q[$];
  result_t want;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t qdec checker: %s", $time, what);
  endtask

  // Quarter step between two AB pairs: map each pair to its place on the
  // Gray cycle 00, 01, 11, 10 and look at the distance; forward is -1 here
  function automatic int quarter_step(input logic [1:0] from_ab, input logic [1:0] to_ab);
    logic [1:0] from_ph;
    logic [1:0] to_ph;
    logic [1:0] phase_gap;
    from_ph   = {from_ab[1], ^from_ab};
    to_ph     = {to_ab[1], ^to_ab};
    phase_gap = to_ph - from_ph;
    case (phase_gap)
      2'd1:    return -1;
      2'd3:    return 1;
      default: return 0;
    endcase
  endfunction

  // Apply one event to the state and return the result it produces
  function automatic result_t decode_event(input logic [2:0] act,
                                           input logic [TIME_BITS-1:0] now,
                                           input logic [1:0] ab);
    result_t              r;
    logic [TIME_BITS-1:0] elapsed;
    int                   step;
    int                   sum;
    r = '0;
    case (act)
      ACT_PIN_CHANGE: begin
        elapsed = now - last_hit;
        if (elapsed >= TIME_BITS'(debounce_q)) begin
          r.accepted = 1'b1;
          last_hit   = now;
          step       = quarter_step(last_ab, ab);
          if (invert_q)
            step = -step;
          if (step != 0) begin
            sum = int'(pos_q) + step;
            if (sum > int'(POS_MAX))
              sum = int'(POS_MAX);
            if (sum < int'(POS_MIN))
              sum = int'(POS_MIN);
            pos_q   = sum[POS_BITS-1:0];
            moved_q = 1'b1;
          end
          last_ab = ab;
        end
      end
      ACT_INIT: begin
        last_ab   = ab;
        pos_q     = '0;
        read_mark = '0;
        moved_q   = 1'b0;
      end
      ACT_RESET_POS: begin
        pos_q   = '0;
        moved_q = 1'b1;
      end
      ACT_READ_DELTA: begin
        r.delta   = pos_q - read_mark;
        read_mark = pos_q;
      end
      default: ;
    endcase
    r.changed_flag = moved_q;
    if (act == ACT_READ_CHANGED)
      moved_q = 1'b0;
    r.position = pos_q;
    return r;
  endfunction

  // Retire output beats first, then take config writes and input beats
  always @(posedge clk) begin
    if (rst) begin
      pos_q      = '0;
      read_mark  = '0;
      last_ab    = '0;
      last_hit   = '0;
      moved_q    = 1'b0;
      debounce_q = DEBOUNCE_RESET;
      invert_q   = INVERT_RESET;
      expected_q.delete();
      errors     = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
          if (delta !== want.delta)
            report_mismatch($sformatf("delta %0d, expected %0d", delta, want.delta));
          if (changed_flag !== want.changed_flag)
            report_mismatch($sformatf("changed_flag %0b, expected %0b",
                                      changed_flag, want.changed_flag));
          if (accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b", accepted, want.accepted));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_DEBOUNCE)
          debounce_q = cfg_data;
        else
          invert_q = cfg_data[0];
      end
      if (in_valid && !in_stall)
        expected_q.push_back(decode_event(action, time_ms, {pin_a, pin_b}));
    end
    pending = expected_q.size();
  end

endmodule

FILE: test/quadrature_decoder_saturating_top_tb.sv
module quadrature_decoder_saturating_top_tb;

  import qdec_pkg::*;

  localparam int         PHASE_ITEMS     = 300;
  localparam int         SQUEEZE_CYCLES  = 300;
  localparam int         STALL_LIMIT     = 2000;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [DEB_BITS-1:0]        cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic [2:0]                 action;
  logic [TIME_BITS-1:0]       time_ms;
  logic                       pin_a;
  logic                       pin_b;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [POS_BITS-1:0] position;
  logic signed [POS_BITS-1:0] delta;
  logic                       changed_flag;
  logic                       accepted;
  int                         errors;
  int                         pending;

  // Stimulus shaping state
  bit                   hold_req = 1'b0;
  bit                   tx_calm  = 1'b0;
  bit                   dir_up   = 1'b1;
  logic [1:0]           gen_ab   = 2'b00;
  logic [TIME_BITS-1:0] base_t   = '0;
  logic [DEB_BITS-1:0]  deb_now  = DEBOUNCE_RESET;

  quadrature_decoder_saturating_top dut (.*);

  quadrature_decoder_saturating_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one beat after a random gap and hold it until it is taken
  task automatic send_beat(input logic [2:0] act, input logic [TIME_BITS-1:0] t,
                           input logic [1:0] ab);
    int gap;
    if ($urandom_range(0, 49) == 0)
      tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    time_ms  <= t;
    pin_a    <= ab[1];
    pin_b    <= ab[0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Write a register once the block has drained
  task automatic write_reg(input cfg_reg_t idx, input logic [DEB_BITS-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly clean rotation runs, with bounces, noise and the other actions mixed in
  task automatic random_item();
    int         pick;
    logic [1:0] ph;
    logic [1:0] next_ab;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      if ($urandom_range(0, 299) == 0)
        dir_up = !dir_up;
      ph      = {gen_ab[1], ^gen_ab};
      ph      = dir_up ? ph + 2'd1 : ph - 2'd1;
      next_ab = {ph[1], ph[1] ^ ph[0]};
      if (deb_now != 0 && $urandom_range(0, 6) == 0) begin
        // contact bounce: too early, so the step must be dropped
        send_beat(ACT_PIN_CHANGE, base_t + $urandom_range(0, int'(deb_now) - 1), next_ab);
      end else begin
        base_t = base_t + deb_now + $urandom_range(0, 3);
        gen_ab = next_ab;
        send_beat(ACT_PIN_CHANGE, base_t, next_ab);
      end
    end else if (pick < 72) begin
      send_beat(ACT_PIN_CHANGE, $urandom, 2'($urandom));
    end else if (pick < 76) begin
      // same pins again: accepted with no step
      base_t = base_t + deb_now + $urandom_range(0, 3);
      send_beat(ACT_PIN_CHANGE, base_t, gen_ab);
    end else if (pick < 88) begin
      send_beat(ACT_READ_DELTA, $urandom, 2'($urandom));
    end else if (pick < 96) begin
      send_beat(ACT_READ_CHANGED, $urandom, 2'($urandom));
    end else if (pick < 98) begin
      send_beat(ACT_RESET_POS, $urandom, 2'($urandom));
    end else if (pick < 99) begin
      gen_ab = 2'($urandom);
      send_beat(ACT_INIT, $urandom, gen_ab);
    end else begin
      send_beat(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), $urandom, 2'($urandom));
    end
  endtask

  task automatic run_phase(input logic [DEB_BITS-1:0] deb, input logic inv, input bit squeeze);
    write_reg(REG_DEBOUNCE, deb);
    deb_now = deb;
    write_reg(REG_INVERT, {7'($urandom), inv});
    base_t = $urandom;
    if (squeeze)
      hold_req = 1'b1;
    send_beat(ACT_INIT, $urandom, gen_ab);
    repeat (PHASE_ITEMS) random_item();
  endtask

  // Result side: random hold-off per beat, plus one long squeeze on request
  initial begin : result_sink
    int hold;
    bit calm;
    out_stall = 1'b0;
    calm      = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 49) == 0)
        calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("quadrature_decoder_saturating_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_PIN_CHANGE;
    time_ms   = '0;
    pin_a     = 1'b0;
    pin_b     = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: debounce near reset, rotation both ways, every action
    send_beat(ACT_PIN_CHANGE, 32'd0, 2'b01);
    send_beat(ACT_PIN_CHANGE, 32'd1, 2'b01);
    send_beat(ACT_PIN_CHANGE, 32'd2, 2'b01);
    send_beat(ACT_PIN_CHANGE, 32'd4, 2'b11);
    send_beat(ACT_PIN_CHANGE, 32'd5, 2'b10);
    send_beat(ACT_PIN_CHANGE, 32'd6, 2'b10);
    send_beat(ACT_PIN_CHANGE, 32'd8, 2'b00);
    send_beat(ACT_PIN_CHANGE, 32'd10, 2'b10);
    send_beat(ACT_PIN_CHANGE, 32'd12, 2'b01);
    send_beat(ACT_READ_DELTA, 32'd13, 2'b00);
    send_beat(ACT_READ_CHANGED, 32'd14, 2'b00);
    send_beat(ACT_READ_CHANGED, 32'd15, 2'b00);
    send_beat(ACT_RESET_POS, 32'd16, 2'b00);
    send_beat(ACT_READ_DELTA, 32'd17, 2'b00);
    send_beat(ACT_INIT, 32'd18, 2'b11);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_beat(3'(a), 32'hFFFF_FFFF, 2'b11);
    // timestamp wrap
    send_beat(ACT_PIN_CHANGE, 32'hFFFF_FFFF, 2'b11);
    send_beat(ACT_PIN_CHANGE, 32'h0000_0000, 2'b01);
    send_beat(ACT_PIN_CHANGE, 32'h0000_0001, 2'b01);
    send_beat(ACT_READ_CHANGED, 32'h0000_0002, 2'b00);
    // zero debounce, forward sense
    write_reg(REG_DEBOUNCE, 8'd0);
    deb_now = 8'd0;
    write_reg(REG_INVERT, 8'd0);
    send_beat(ACT_PIN_CHANGE, 32'd1, 2'b01);
    send_beat(ACT_PIN_CHANGE, 32'd1, 2'b00);
    send_beat(ACT_READ_DELTA, 32'd1, 2'b00);

    // Random phases over several settings, extremes included
    run_phase(8'd0, 1'b0, 1'b0);
    run_phase(8'd255, 1'b1, 1'b1);
    run_phase(8'd1, 1'b0, 1'b0);
    run_phase(8'd7, 1'b1, 1'b0);
    run_phase(8'($urandom), 1'($urandom), 1'b0);
    run_phase(DEBOUNCE_RESET, INVERT_RESET, 1'b0);

    // Drain and settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("quadrature_decoder_saturating_top_tb: done, clean");
    else
      $display("quadrature_decoder_saturating_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: quadrature_decoder_saturating_top.f
sv/qdec_pkg.sv
sv/qdec_in_stage.sv
sv/qdec_core.sv
sv/qdec_out_stage.sv
sv/quadrature_decoder_saturating_top.sv
test/quadrature_decoder_saturating_checker.sv
test/quadrature_decoder_saturating_top_tb.sv
